### sv/earliest_free_server_dispatch_macros.svh
// Assertion helpers used by earliest_free_server_dispatch.sv.
`ifndef EARLIEST_FREE_SERVER_DISPATCH_MACROS_SVH
`define EARLIEST_FREE_SERVER_DISPATCH_MACROS_SVH

// Check outside reset only.
`define EFSD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define EFSD_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/efsd_pkg.sv
`timescale 1ns / 1ps
package efsd_pkg;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_SORT = 2'd2,
    CELL_CLR  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
  } cell_ctl_t;

endpackage

### sv/efsd_cell.sv
`timescale 1ns / 1ps
module efsd_cell #(
  parameter int            IW     = 6,
  parameter int            NW     = 7,
  parameter logic [IW-1:0] RST_ID = '0,
  parameter bit            ODD    = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  efsd_pkg::cell_ctl_t ctl,
  input  logic [NW-1:0]       n_eff,
  input  logic [31:0]         new_fin,
  input  logic [IW-1:0]       new_id,
  input  logic [31:0]         left_fin,
  input  logic [IW-1:0]       left_id,
  input  logic                left_lt_new,
  input  logic                left_swap,
  input  logic                right_vld,
  input  logic                right_inact,
  input  logic [31:0]         right_fin,
  input  logic [IW-1:0]       right_id,
  input  logic                right_lt_new,
  output logic [31:0]         fin_o,
  output logic [IW-1:0]       id_o,
  output logic [IW-1:0]       id_nxt_o,
  output logic                inact_o,
  output logic                lt_new_o,
  output logic                swap_o
);

  logic [31:0]   fin_r, fin_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic          inact;
  logic [IW+32:0] own_key, right_key, new_key;

  assign inact     = NW'(id_r) >= n_eff;
  assign own_key   = {inact, fin_r, id_r};
  assign right_key = {right_inact, right_fin, right_id};
  assign new_key   = {1'b0, new_fin, new_id};

  assign lt_new_o = own_key <= new_key;
  assign swap_o   = right_vld && (right_key < own_key);

  always_comb begin
    fin_nxt = fin_r;
    id_nxt  = id_r;
    unique case (ctl.op)
      efsd_pkg::CELL_HOLD: begin
      end
      efsd_pkg::CELL_INS: begin
        if (right_lt_new) begin
          fin_nxt = right_fin;
          id_nxt  = right_id;
        end else if (left_lt_new && lt_new_o) begin
          fin_nxt = new_fin;
          id_nxt  = new_id;
        end
      end
      efsd_pkg::CELL_SORT: begin
        if (ctl.phase == ODD) begin
          if (swap_o) begin
            fin_nxt = right_fin;
            id_nxt  = right_id;
          end
        end else if (left_swap) begin
          fin_nxt = left_fin;
          id_nxt  = left_id;
        end
      end
      efsd_pkg::CELL_CLR: begin
        if (!inact) begin
          fin_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r <= '0;
      id_r  <= RST_ID;
    end else begin
      fin_r <= fin_nxt;
      id_r  <= id_nxt;
    end
  end

  assign fin_o    = fin_r;
  assign id_o     = id_r;
  assign id_nxt_o = id_nxt;
  assign inact_o  = inact;

endmodule

### sv/earliest_free_server_dispatch.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// in        in_valid/in_ready    in_action, in_service_time
// out       out_valid/out_ready  out_assigned_server, out_assigned_finish, out_next_server
// cfg       cfg_valid/cfg_ready  cfg_num_servers
//
// Assign: accept, saturating add on the head cell, then sorted insert.
// Clear: accept, then the odd-even transposition pass over the cell chain restores
//   server order.
// Config write: accept, then the same sort pass; no beat on out.
// Reset leaves the chain sorted with server 1 at the head; nothing to sweep.
// A stalled out channel holds the block in its last step; in and cfg are taken when idle.
`include "earliest_free_server_dispatch_macros.svh"
module earliest_free_server_dispatch #(
  parameter int MAX_SERVERS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [15:0] in_service_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_assigned_server,
  output logic [31:0] out_assigned_finish,
  output logic [6:0]  out_next_server,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_num_servers
);

  localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int NW = $clog2(MAX_SERVERS + 1);
  localparam int XW = (NW > 7) ? NW : 7;
  localparam logic ACT_CLEAR = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUM  = 5'b00010,
    S_INS  = 5'b00100,
    S_SORT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [NW-1:0] n_eff_r, n_eff_nxt, cnt_r, cnt_nxt;
  logic          emit_r, emit_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   service_r, service_nxt;
  logic [31:0]   sum_r, sum_nxt;
  logic [IW-1:0] hid_r, hid_nxt;
  logic [6:0]    srv_r, srv_nxt, next_r, next_nxt;
  logic [31:0]   fin_out_r, fin_out_nxt;

  efsd_pkg::cell_ctl_t ctl;

  logic [31:0]   fin_w    [MAX_SERVERS];
  logic [IW-1:0] id_w     [MAX_SERVERS];
  logic [IW-1:0] id_nxt_w [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] inact_w, lt_w, swp_w;

  logic          out_free, in_acc, cfg_acc;
  logic [XW-1:0] cfg_x;
  logic [32:0]   sum_w;
  logic [IW:0]   hsrv_w, nsrv_w;

  assign cfg_ready = state_r == S_IDLE;
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign cfg_x  = XW'(cfg_num_servers);
  assign sum_w  = {1'b0, fin_w[0]} + 33'(service_r);
  assign hsrv_w = (IW+1)'(hid_r) + (IW+1)'(1);
  assign nsrv_w = (IW+1)'(id_nxt_w[0]) + (IW+1)'(1);

  always_comb begin
    state_nxt     = state_r;
    n_eff_nxt     = n_eff_r;
    cnt_nxt       = cnt_r;
    emit_nxt      = emit_r;
    service_nxt   = service_r;
    sum_nxt       = sum_r;
    hid_nxt       = hid_r;
    srv_nxt       = srv_r;
    next_nxt      = next_r;
    fin_out_nxt   = fin_out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    ctl.op        = efsd_pkg::CELL_HOLD;
    ctl.phase     = cnt_r[0];
    unique case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          if (cfg_x == '0) begin
            n_eff_nxt = NW'(1);
          end else if (cfg_x > XW'(MAX_SERVERS)) begin
            n_eff_nxt = NW'(MAX_SERVERS);
          end else begin
            n_eff_nxt = NW'(cfg_x);
          end
          cnt_nxt   = '0;
          emit_nxt  = 1'b0;
          state_nxt = S_SORT;
        end else if (in_acc) begin
          service_nxt = in_service_time;
          if (in_action == ACT_CLEAR) begin
            ctl.op    = efsd_pkg::CELL_CLR;
            cnt_nxt   = '0;
            emit_nxt  = 1'b1;
            state_nxt = S_SORT;
          end else begin
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        sum_nxt   = sum_w[32] ? '1 : sum_w[31:0];
        hid_nxt   = id_w[0];
        state_nxt = S_INS;
      end
      S_INS: begin
        if (out_free) begin
          ctl.op        = efsd_pkg::CELL_INS;
          srv_nxt       = 7'(hsrv_w);
          fin_out_nxt   = sum_r;
          next_nxt      = 7'(nsrv_w);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SORT: begin
        ctl.op  = efsd_pkg::CELL_SORT;
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == NW'(MAX_SERVERS - 1)) begin
          state_nxt = emit_r ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          srv_nxt       = '0;
          fin_out_nxt   = '0;
          next_nxt      = 7'(nsrv_w);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_eff_r     <= NW'(1);
      cnt_r       <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_eff_r     <= n_eff_nxt;
      cnt_r       <= cnt_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    service_r <= service_nxt;
    sum_r     <= sum_nxt;
    hid_r     <= hid_nxt;
    srv_r     <= srv_nxt;
    next_r    <= next_nxt;
    fin_out_r <= fin_out_nxt;
  end

  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    logic [31:0]   l_fin, r_fin;
    logic [IW-1:0] l_id, r_id;
    logic          l_lt, l_swp, r_vld, r_inact, r_lt;

    if (i == 0) begin : g_head
      assign l_fin = '0;
      assign l_id  = '0;
      assign l_lt  = 1'b1;
      assign l_swp = 1'b0;
    end else begin : g_left
      assign l_fin = fin_w[i-1];
      assign l_id  = id_w[i-1];
      assign l_lt  = lt_w[i-1];
      assign l_swp = swp_w[i-1];
    end

    if (i == MAX_SERVERS - 1) begin : g_tail
      assign r_vld   = 1'b0;
      assign r_inact = 1'b1;
      assign r_fin   = '0;
      assign r_id    = '0;
      assign r_lt    = 1'b0;
    end else begin : g_right
      assign r_vld   = 1'b1;
      assign r_inact = inact_w[i+1];
      assign r_fin   = fin_w[i+1];
      assign r_id    = id_w[i+1];
      assign r_lt    = lt_w[i+1];
    end

    efsd_cell #(
      .IW     (IW),
      .NW     (NW),
      .RST_ID (IW'(i)),
      .ODD    (1'(i % 2))
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .n_eff        (n_eff_r),
      .new_fin      (sum_r),
      .new_id       (hid_r),
      .left_fin     (l_fin),
      .left_id      (l_id),
      .left_lt_new  (l_lt),
      .left_swap    (l_swp),
      .right_vld    (r_vld),
      .right_inact  (r_inact),
      .right_fin    (r_fin),
      .right_id     (r_id),
      .right_lt_new (r_lt),
      .fin_o        (fin_w[i]),
      .id_o         (id_w[i]),
      .id_nxt_o     (id_nxt_w[i]),
      .inact_o      (inact_w[i]),
      .lt_new_o     (lt_w[i]),
      .swap_o       (swp_w[i])
    );
  end

  assign out_valid           = out_valid_r;
  assign out_assigned_server = srv_r;
  assign out_assigned_finish = fin_out_r;
  assign out_next_server     = next_r;

  `EFSD_ASSERT_RST(a_head_active, state_r == S_IDLE |-> !inact_w[0], "idle head cell inactive")
  `EFSD_ASSERT_RST(a_chain_sorted, state_r == S_IDLE |-> swp_w == '0, "idle chain out of order")
  `EFSD_ASSERT_RST(a_accept_busy, in_acc || cfg_acc |=> state_r != S_IDLE, "beat taken but idle")
  `EFSD_ASSERT_ALL(a_ins_emit, rst_n && state_r == S_INS && out_free |=> out_valid_r, "insert without beat")

endmodule
